### src/stq_pkg.sv
// Shared types and constants for the sorted timer expiry queue.
// Depends on nothing; stq_ctrl, the top level and the testbench import it.
package stq_pkg;

   localparam int DEPTH_DEFAULT   = 64;
   localparam int ID_BITS_DEFAULT = 10;
   localparam int MAX_RESULTS     = 64;
   localparam int TIME_BITS       = 32;
   localparam int PORT_ID_BITS    = 10;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_ADJUST = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_EXPIRED   = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_DUPLICATE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_EV,
      S_DEC,
      S_MRD,
      S_MWR,
      S_FIN
   } state_type;

endpackage

### src/stq_mem.sv
// Entry table: one write port and one registered read port.
// Depends on nothing beyond its parameters.
module stq_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 42
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/stq_ctrl.sv
// Sequencer for the timer table: scans, shifts and writes back entries.
// Depends on stq_pkg and drives the stq_mem ports.
module stq_ctrl #(
   parameter int DEPTH   = stq_pkg::DEPTH_DEFAULT,
   parameter int ID_BITS = stq_pkg::ID_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  stq_pkg::action_type                 req_action,
   input  logic [ID_BITS-1:0]                  req_id,
   input  logic [stq_pkg::TIME_BITS-1:0]       req_time,
   output logic                                rsp_strobe,
   output stq_pkg::status_type                 rsp_status,
   output logic [ID_BITS-1:0]                  rsp_id,
   output logic                                rsp_last,
   output logic                                mem_we,
   output logic [$clog2(DEPTH)-1:0]            mem_waddr,
   output logic [stq_pkg::TIME_BITS+ID_BITS-1:0] mem_wdata,
   output logic [$clog2(DEPTH)-1:0]            mem_raddr,
   input  logic [stq_pkg::TIME_BITS+ID_BITS-1:0] mem_rdata
);
   import stq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = TIME_BITS + ID_BITS;

   state_type            state_ff, state_in;
   action_type           act_ff, act_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] t_ff, t_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        ins_ff, ins_in;
   logic                 ins_set_ff, ins_set_in;
   logic                 pend_ff, pend_in;
   logic [ID_BITS-1:0]   pend_id_ff, pend_id_in;
   logic [CW-1:0]        src_ff, src_in;
   logic [CW-1:0]        lim_ff, lim_in;
   logic [CW-1:0]        off_ff, off_in;
   logic                 up_ff, up_in;
   logic                 fin_we_ff, fin_we_in;
   logic [CW-1:0]        fin_addr_ff, fin_addr_in;
   logic                 fin_rsp_ff, fin_rsp_in;
   status_type           fin_st_ff, fin_st_in;
   logic                 rsp_v_ff, rsp_v_in;
   status_type           rsp_st_ff, rsp_st_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [TIME_BITS-1:0] rd_exp;
   logic [ID_BITS-1:0]   rd_id;
   logic [CW-1:0]        q_pos;
   logic [CW-1:0]        rd_idx;
   logic [CW-1:0]        wr_idx;

   assign rd_exp = mem_rdata[EW-1:ID_BITS];
   assign rd_id  = mem_rdata[ID_BITS-1:0];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_v_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_v_ff <= rsp_v_in;
         pend_ff  <= pend_in;
      end
   end

   // Working registers for the item in hand.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      id_ff       <= id_in;
      t_ff        <= t_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      ins_ff      <= ins_in;
      ins_set_ff  <= ins_set_in;
      pend_id_ff  <= pend_id_in;
      src_ff      <= src_in;
      lim_ff      <= lim_in;
      off_ff      <= off_in;
      up_ff       <= up_in;
      fin_we_ff   <= fin_we_in;
      fin_addr_ff <= fin_addr_in;
      fin_rsp_ff  <= fin_rsp_in;
      fin_st_ff   <= fin_st_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Next state, table accesses and results.
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      id_in       = id_ff;
      t_in        = t_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      ins_in      = ins_ff;
      ins_set_in  = ins_set_ff;
      pend_in     = pend_ff;
      pend_id_in  = pend_id_ff;
      src_in      = src_ff;
      lim_in      = lim_ff;
      off_in      = off_ff;
      up_in       = up_ff;
      fin_we_in   = fin_we_ff;
      fin_addr_in = fin_addr_ff;
      fin_rsp_in  = fin_rsp_ff;
      fin_st_in   = fin_st_ff;
      rsp_v_in    = 1'b0;
      rsp_st_in   = rsp_st_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_last_in = rsp_last_ff;
      rd_idx      = idx_ff;
      wr_idx      = fin_addr_ff;
      mem_we      = 1'b0;
      mem_wdata   = {t_ff, id_ff};
      q_pos       = ins_set_ff ? ins_ff : count_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in     = req_action;
               id_in      = req_id;
               t_in       = req_time;
               idx_in     = '0;
               found_in   = 1'b0;
               pos_in     = '0;
               ins_set_in = 1'b0;
               pend_in    = 1'b0;
               state_in   = S_RD;
            end
         end
         // Issue the read of the next entry, or end the scan.
         S_RD: begin
            if (idx_ff >= count_ff ||
                (act_ff == ACT_TICK && 32'(idx_ff) >= 32'(MAX_RESULTS))) begin
               state_in = S_DEC;
            end else begin
               state_in = S_EV;
            end
         end
         // Look at the entry just read.
         S_EV: begin
            idx_in   = idx_ff + 1'b1;
            state_in = S_RD;
            case (act_ff)
               ACT_ADD: begin
                  if (rd_id == id_ff) begin
                     found_in = 1'b1;
                     state_in = S_DEC;
                  end else if (!ins_set_ff && rd_exp > t_ff) begin
                     ins_in     = idx_ff;
                     ins_set_in = 1'b1;
                  end
               end
               ACT_ADJUST: begin
                  if (!found_ff) begin
                     if (rd_id == id_ff) begin
                        found_in = 1'b1;
                        pos_in   = idx_ff;
                     end
                  end else if (rd_exp > t_ff) begin
                     ins_in     = idx_ff;
                     ins_set_in = 1'b1;
                     state_in   = S_DEC;
                  end
               end
               ACT_DELETE: begin
                  if (rd_id == id_ff) begin
                     found_in = 1'b1;
                     pos_in   = idx_ff;
                     state_in = S_DEC;
                  end
               end
               ACT_TICK: begin
                  if (rd_exp <= t_ff) begin
                     // The held item is not the final one: send it now.
                     if (pend_ff) begin
                        rsp_v_in    = 1'b1;
                        rsp_st_in   = ST_EXPIRED;
                        rsp_id_in   = pend_id_ff;
                        rsp_last_in = 1'b0;
                     end
                     pend_in    = 1'b1;
                     pend_id_in = rd_id;
                     pos_in     = idx_ff + 1'b1;
                  end else begin
                     state_in = S_DEC;
                  end
               end
               default: state_in = S_DEC;
            endcase
         end
         // Decide the outcome and set up the shift.
         S_DEC: begin
            fin_we_in  = 1'b0;
            fin_rsp_in = 1'b1;
            fin_st_in  = ST_DONE;
            up_in      = 1'b0;
            off_in     = CW'(1);
            src_in     = '0;
            lim_in     = '0;
            state_in   = S_MRD;
            case (act_ff)
               ACT_ADD: begin
                  if (found_ff) begin
                     fin_st_in = ST_DUPLICATE;
                  end else if (count_ff == CW'(DEPTH)) begin
                     fin_st_in = ST_FULL;
                  end else begin
                     up_in       = 1'b1;
                     src_in      = count_ff;
                     lim_in      = q_pos;
                     fin_we_in   = 1'b1;
                     fin_addr_in = q_pos;
                     count_in    = count_ff + 1'b1;
                  end
               end
               ACT_ADJUST: begin
                  if (!found_ff) begin
                     fin_st_in = ST_NOT_FOUND;
                  end else if (q_pos > pos_ff + 1'b1) begin
                     src_in      = pos_ff + 1'b1;
                     lim_in      = q_pos;
                     fin_we_in   = 1'b1;
                     fin_addr_in = q_pos - 1'b1;
                  end else begin
                     fin_we_in   = 1'b1;
                     fin_addr_in = pos_ff;
                  end
               end
               ACT_DELETE: begin
                  if (!found_ff) begin
                     fin_st_in = ST_NOT_FOUND;
                  end else begin
                     src_in   = pos_ff + 1'b1;
                     lim_in   = count_ff;
                     count_in = count_ff - 1'b1;
                  end
               end
               ACT_TICK: begin
                  // Final result of the tick; then close the gap at the front.
                  fin_rsp_in  = 1'b0;
                  rsp_v_in    = 1'b1;
                  rsp_last_in = 1'b1;
                  if (pend_ff) begin
                     rsp_st_in = ST_EXPIRED;
                     rsp_id_in = pend_id_ff;
                  end else begin
                     rsp_st_in = ST_DONE;
                     rsp_id_in = '0;
                  end
                  pend_in  = 1'b0;
                  src_in   = pos_ff;
                  lim_in   = count_ff;
                  off_in   = pos_ff;
                  count_in = count_ff - pos_ff;
               end
               default: fin_rsp_in = 1'b1;
            endcase
         end
         // Shift loop: read one entry.
         S_MRD: begin
            if (up_ff) begin
               rd_idx   = src_ff - 1'b1;
               state_in = (src_ff > lim_ff) ? S_MWR : S_FIN;
            end else begin
               rd_idx   = src_ff;
               state_in = (src_ff < lim_ff) ? S_MWR : S_FIN;
            end
         end
         // Shift loop: write it one place later, or off_ff places earlier.
         S_MWR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            if (up_ff) begin
               wr_idx = src_ff;
               src_in = src_ff - 1'b1;
            end else begin
               wr_idx = src_ff - off_ff;
               src_in = src_ff + 1'b1;
            end
            state_in = S_MRD;
         end
         // Place the new entry if there is one, and report unless the item is a tick.
         S_FIN: begin
            mem_we = fin_we_ff;
            if (fin_rsp_ff) begin
               rsp_v_in    = 1'b1;
               rsp_st_in   = fin_st_ff;
               rsp_id_in   = id_ff;
               rsp_last_in = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign mem_raddr  = rd_idx[AW-1:0];
   assign mem_waddr  = wr_idx[AW-1:0];
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_v_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### src/sorted_timer_expiry_queue_top.sv
// Top level of the sorted timer expiry queue: sequencer plus entry table.
// Depends on stq_pkg, stq_ctrl and stq_mem.
//
// Each scanned entry passes S_RD and S_EV, each shifted entry S_MRD and
// S_MWR, as the table memory has a single read port. A tick gives one
// result per expired entry, up to MAX_RESULTS, or one ST_DONE if none
// expired, each on rsp_strobe for one cycle; results cannot be stalled.
module sorted_timer_expiry_queue_top #(
   parameter int DEPTH   = stq_pkg::DEPTH_DEFAULT,
   parameter int ID_BITS = stq_pkg::ID_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [9:0]  req_timer_id,
   input  logic [31:0] req_time_value,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_out_id,
   output logic        rsp_last
);
   import stq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int EW = TIME_BITS + ID_BITS;

   logic [ID_BITS-1:0] id_int;
   logic [ID_BITS-1:0] rsp_id_int;
   status_type         st_int;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   logic [EW-1:0]      mem_wdata;
   logic [EW-1:0]      mem_rdata;

   // Identifier width conversion between the ports and the table.
   for (genvar b = 0; b < ID_BITS; b++) begin : g_id_in
      if (b < PORT_ID_BITS) begin : g_bit
         assign id_int[b] = req_timer_id[b];
      end else begin : g_zero
         assign id_int[b] = 1'b0;
      end
   end
   for (genvar b = 0; b < PORT_ID_BITS; b++) begin : g_id_out
      if (b < ID_BITS) begin : g_bit
         assign rsp_out_id[b] = rsp_id_int[b];
      end else begin : g_zero
         assign rsp_out_id[b] = 1'b0;
      end
   end

   assign rsp_status = st_int;

   stq_ctrl #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (action_type'(req_action)),
      .req_id     (id_int),
      .req_time   (req_time_value),
      .rsp_strobe (rsp_strobe),
      .rsp_status (st_int),
      .rsp_id     (rsp_id_int),
      .rsp_last   (rsp_last),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   stq_mem #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

### verif/tb_sorted_timer_expiry_queue_top.sv
// Testbench for the sorted timer expiry queue: directed and random items with a
// self-checking predictor of the ordered timer table. Depends on stq_pkg and the top level.
module tb_sorted_timer_expiry_queue_top;
   import stq_pkg::*;

   localparam int NSLOT = 64;

   typedef struct packed {
      action_type  action;
      logic [9:0]  timer_id;
      logic [31:0] time_value;
   } timer_item_t;

   typedef struct packed {
      status_type  status;
      logic [9:0]  out_id;
      logic        last;
   } expiry_result_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [9:0]  req_timer_id;
   logic [31:0] req_time_value;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_out_id;
   logic        rsp_last;

   sorted_timer_expiry_queue_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_timer_id(req_timer_id),
      .req_time_value(req_time_value), .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status), .rsp_out_id(rsp_out_id), .rsp_last(rsp_last)
   );

   // Predictor copy of the timer table.
   logic [31:0] tbl_expiry [NSLOT];
   logic [9:0]  tbl_ident  [NSLOT];
   int          tbl_count;

   timer_item_t    pending_items[$];
   expiry_result_t expected_results[$];
   int             fail_count;
   int             idle_pct;
   bit             stim_done;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int find_timer(logic [9:0] id);
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_ident[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < tbl_count; i++) begin
         tbl_expiry[i] = tbl_expiry[i + 1];
         tbl_ident[i]  = tbl_ident[i + 1];
      end
      if (tbl_count > 0) tbl_count--;
   endfunction

   // Insert at the first slot at or after the start whose expiry is later.
   function automatic void place_timer(int from, logic [9:0] id, logic [31:0] t);
      int pos;
      pos = from;
      while (pos < tbl_count && tbl_expiry[pos] <= t) pos++;
      for (int i = tbl_count; i > pos; i--) begin
         tbl_expiry[i] = tbl_expiry[i - 1];
         tbl_ident[i]  = tbl_ident[i - 1];
      end
      tbl_expiry[pos] = t;
      tbl_ident[pos]  = id;
      tbl_count++;
   endfunction

   function automatic void push_result(status_type st, logic [9:0] id, logic lst);
      expiry_result_t r;
      r.status = st;
      r.out_id = id;
      r.last   = lst;
      expected_results.push_back(r);
   endfunction

   // Work out the results an accepted item causes and update the table.
   function automatic void predict_expiry(timer_item_t it);
      int pos;
      int n;
      case (it.action)
         ACT_ADD: begin
            if (find_timer(it.timer_id) >= 0) push_result(ST_DUPLICATE, it.timer_id, 1'b1);
            else if (tbl_count >= NSLOT) push_result(ST_FULL, it.timer_id, 1'b1);
            else begin
               place_timer(0, it.timer_id, it.time_value);
               push_result(ST_DONE, it.timer_id, 1'b1);
            end
         end
         ACT_ADJUST: begin
            pos = find_timer(it.timer_id);
            if (pos < 0) push_result(ST_NOT_FOUND, it.timer_id, 1'b1);
            else begin
               tbl_expiry[pos] = it.time_value;
               if (pos + 1 < tbl_count && it.time_value >= tbl_expiry[pos + 1]) begin
                  drop_slot(pos);
                  place_timer(pos, it.timer_id, it.time_value);
               end
               push_result(ST_DONE, it.timer_id, 1'b1);
            end
         end
         ACT_DELETE: begin
            pos = find_timer(it.timer_id);
            if (pos < 0) push_result(ST_NOT_FOUND, it.timer_id, 1'b1);
            else begin
               drop_slot(pos);
               push_result(ST_DONE, it.timer_id, 1'b1);
            end
         end
         default: begin
            n = 0;
            while (n < MAX_RESULTS && tbl_count > 0 && tbl_expiry[0] <= it.time_value) begin
               push_result(ST_EXPIRED, tbl_ident[0],
                           (n == MAX_RESULTS - 1 || tbl_count == 1 ||
                            tbl_expiry[1] > it.time_value));
               drop_slot(0);
               n++;
            end
            if (n == 0) push_result(ST_DONE, 10'd0, 1'b1);
         end
      endcase
   endfunction

   // Driver: present items at the falling edge while the block is idle, with
   // random sender gaps. An item shown while busy is low is taken at the next
   // rising edge, so start drops again at the following falling edge.
   always @(negedge clock) begin
      timer_item_t it;
      if (reset) begin
         start <= 1'b0;
      end else if (!busy && pending_items.size() > 0 &&
                   $urandom_range(99, 0) >= idle_pct) begin
         it = pending_items.pop_front();
         req_action     <= it.action;
         req_timer_id   <= it.timer_id;
         req_time_value <= it.time_value;
         start          <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predict on acceptance and check each result strobe.
   always @(posedge clock) begin
      timer_item_t    it;
      expiry_result_t want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result status=%0d id=%0d last=%0b",
                        $realtime, rsp_status, rsp_out_id, rsp_last);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $realtime, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_out_id !== want.out_id) begin
                  $display("%0t: out_id expected %0d actual %0d",
                           $realtime, want.out_id, rsp_out_id);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b",
                           $realtime, want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            it.action     = action_type'(req_action);
            it.timer_id   = req_timer_id;
            it.time_value = req_time_value;
            predict_expiry(it);
         end
      end
   end

   function automatic timer_item_t make_item(action_type a, logic [9:0] id, logic [31:0] t);
      timer_item_t it;
      it.action     = a;
      it.timer_id   = id;
      it.time_value = t;
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || start || busy || expected_results.size() > 0)
         @(posedge clock);
   endtask

   // Stimulus: directed corners, then random phases with varying gaps.
   initial begin
      logic [9:0]  id;
      logic [31:0] now;
      logic [31:0] t;
      int          roll;
      fail_count     = 0;
      idle_pct       = 0;
      stim_done      = 1'b0;
      start          = 1'b0;
      req_action     = 2'd0;
      req_timer_id   = 10'd0;
      req_time_value = 32'd0;
      tbl_count      = 0;
      reset          = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty-table misses, field extremes, duplicates and ties in arrival order.
      pending_items.push_back(make_item(ACT_TICK, 10'd0, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(ACT_DELETE, 10'd1023, 32'd0));
      pending_items.push_back(make_item(ACT_ADJUST, 10'd0, 32'd5));
      pending_items.push_back(make_item(ACT_ADD, 10'd1023, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(ACT_ADD, 10'd0, 32'd0));
      pending_items.push_back(make_item(ACT_ADD, 10'd0, 32'd7));
      pending_items.push_back(make_item(ACT_ADD, 10'd5, 32'd100));
      pending_items.push_back(make_item(ACT_ADD, 10'd6, 32'd100));
      pending_items.push_back(make_item(ACT_ADD, 10'd7, 32'd50));
      // Adjust that keeps its place, and one that moves an entry later.
      pending_items.push_back(make_item(ACT_ADJUST, 10'd7, 32'd10));
      pending_items.push_back(make_item(ACT_ADJUST, 10'd0, 32'd60));
      // Adjust that moves an entry later, and one of the last entry.
      pending_items.push_back(make_item(ACT_ADJUST, 10'd5, 32'd100));
      pending_items.push_back(make_item(ACT_ADJUST, 10'd1023, 32'd3));
      pending_items.push_back(make_item(ACT_DELETE, 10'd6, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(ACT_TICK, 10'd1023, 32'd0));
      pending_items.push_back(make_item(ACT_TICK, 10'd0, 32'd99));
      pending_items.push_back(make_item(ACT_TICK, 10'd0, 32'hFFFF_FFFF));
      wait_drained();

      // Fill the table to the full mark, then one tick pops all of it.
      for (int i = 0; i < NSLOT; i++)
         pending_items.push_back(make_item(ACT_ADD, 10'(i * 16 + 1), $urandom_range(40, 0)));
      pending_items.push_back(make_item(ACT_ADD, 10'd999, 32'd1));
      pending_items.push_back(make_item(ACT_ADD, 10'd1, 32'd1));
      pending_items.push_back(make_item(ACT_TICK, 10'd0, 32'd1000));
      wait_drained();

      // Random phases: no gaps, sparse sender, light gaps, then no gaps with a drain.
      now = 32'd0;
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 88 : (ph == 2) ? 8 : 0;
         for (int k = 0; k < 60; k++) begin
            // Halfway through the last phase the sender holds off until the
            // block has drained.
            if (ph == 3 && k == 30) wait_drained();
            roll = $urandom_range(99, 0);
            id   = (roll < 90) ? 10'($urandom_range(47, 0)) : 10'($urandom);
            t    = ($urandom_range(9, 0) == 0) ? $urandom : now + $urandom_range(200, 0);
            if (roll < 40)
               pending_items.push_back(make_item(ACT_ADD, id, t));
            else if (roll < 60)
               pending_items.push_back(make_item(ACT_ADJUST, id, t));
            else if (roll < 75)
               pending_items.push_back(make_item(ACT_DELETE, id, $urandom));
            else begin
               now = now + $urandom_range(120, 0);
               pending_items.push_back(make_item(ACT_TICK, 10'($urandom), now));
            end
         end
         wait_drained();
      end
      pending_items.push_back(make_item(ACT_TICK, 10'd0, 32'hFFFF_FFFF));
      wait_drained();
      repeat (300) @(posedge clock);
      stim_done = 1'b1;
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Timeout guard.
   initial begin
      #40000000;
      if (!stim_done) $display("Regression FAIL");
      $finish;
   end

endmodule
